// ===== sv/assert_macros.svh =====
// Assertion macros shared by the percent decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Most words that one input byte can give.
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  typedef logic [1:0] res_cnt_t;

  // Words given by one accepted byte, in order from slot 0.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    res_cnt_t               count;
    logic                   str_last;
  } pcd_res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/pcd_decode.sv =====
`default_nettype none
`include "assert_macros.svh"

module pcd_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  input  wire logic            acc,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output pcd_pkg::pcd_res_t    res
);
  import pcd_pkg::*;

  logic            plus_as_space;
  phase_t          phase;
  phase_t          phase_next;
  logic [7:0]      held_digit;
  logic [7:0]      held_digit_next;

  logic [MaxRes-1:0][7:0] bytes;
  res_cnt_t        n;
  logic            do_plain;
  logic [7:0]      plain_byte;

  assign plain_byte = (plus_as_space && (in_byte == CH_PLUS)) ? CH_SPACE : in_byte;

  always_comb begin
    bytes           = '0;
    n               = '0;
    phase_next      = PH_IDLE;
    held_digit_next = held_digit;
    do_plain        = 1'b0;

    // Broken or finished escapes first, then the byte itself if still pending.
    unique case (phase)
      PH_PCT: begin
        if (is_hex(in_byte)) begin
          held_digit_next = in_byte;
          phase_next      = PH_DIG;
        end else begin
          bytes[n] = CH_PERCENT;
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIG: begin
        if (is_hex(in_byte) && is_hex(held_digit)) begin
          bytes[n] = {hex_val(held_digit), hex_val(in_byte)};
          n        = n + 2'd1;
        end else begin
          bytes[n] = CH_PERCENT;
          n        = n + 2'd1;
          bytes[n] = held_digit;
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == CH_PERCENT) begin
        phase_next = PH_PCT;
      end else begin
        bytes[n] = plain_byte;
        n        = n + 2'd1;
      end
    end

    // Flush whatever the last byte leaves held.
    if (in_last) begin
      if (phase_next == PH_PCT) begin
        bytes[n] = CH_PERCENT;
        n        = n + 2'd1;
      end else if (phase_next == PH_DIG) begin
        bytes[n] = CH_PERCENT;
        n        = n + 2'd1;
        bytes[n] = held_digit_next;
        n        = n + 2'd1;
      end
      phase_next = PH_IDLE;
    end
  end

  assign res.bytes    = bytes;
  assign res.count    = n;
  assign res.str_last = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b0;
      phase         <= PH_IDLE;
      held_digit    <= '0;
    end else begin
      if (cfg_we) begin
        plus_as_space <= cfg_wdata;
      end
      if (acc) begin
        phase      <= phase_next;
        held_digit <= held_digit_next;
      end
    end
  end

  `ASSERT_CLK(a_last_gives_word, (acc && in_last) |-> (n != 2'd0), "last byte gave no word")
  `ASSERT_CLK(a_last_clears, (acc && in_last) |=> (phase == PH_IDLE), "escape held past last byte")

endmodule

`default_nettype wire

// ===== sv/pcd_outbuf.sv =====
`default_nettype none
`include "assert_macros.svh"

module pcd_outbuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire pcd_pkg::pcd_res_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 string_end
);
  import pcd_pkg::*;

  logic [MaxRes-1:0][7:0] bytes;
  logic                   str_last;
  res_cnt_t               cnt;
  res_cnt_t               idx;
  logic                   pop;

  assign out_valid  = (cnt != 2'd0);
  assign pop        = out_valid && out_ready;
  assign out_byte   = bytes[idx];
  assign run_last   = (cnt == 2'd1);
  assign string_end = (cnt == 2'd1) && str_last;
  // Take a new byte when empty or as the final word leaves this cycle.
  assign can_load   = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= res.count;
      idx <= '0;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= res.bytes;
      str_last <= res.str_last;
    end
  end

  `ASSERT_CLK(a_slot_range, (cnt != 2'd0) |-> ({1'b0, idx} + {1'b0, cnt} <= 3'd3),
    "word slot out of range")
  `ASSERT_CLK(a_load_safe, load |-> ((cnt == 2'd0) || ((cnt == 2'd1) && pop)),
    "waiting word overwritten")
  `ASSERT_CLK(a_load_restart, load |=> (idx == 2'd0), "slot index not restarted")

endmodule

`default_nettype wire

// ===== sv/percent_decoder.sv =====
// URL percent decoder. Raw bytes enter on in_byte/in_last, one per cycle;
// decoded words leave on out_byte with run_last marking the final word of
// each input byte and string_end the final word of the string. Every input
// byte gives zero to three words, so the input side runs at one byte per
// cycle while each byte gives at most one word and out_ready is high; a
// byte giving more holds the input until its last word leaves the single
// three-slot result register, which sends one word a cycle if out_ready.
// Write plus_as_space through cfg_we/cfg_wdata only while idle.
`default_nettype none

module percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            string_end
);
  import pcd_pkg::*;

  pcd_res_t res;
  logic     acc;
  logic     can_load;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;

  pcd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res       (res)
  );

  pcd_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (acc),
    .res        (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

`default_nettype wire
